@@ hw/rtl/owbm_pkg.sv @@
package owbm_pkg;

   // Configuration register file
   localparam int CFG_W       = 10;
   localparam int NUM_REGS    = 7;
   localparam int CFG_ADDR_W  = 3;

   // Defaults handed to the top-level parameters
   localparam int TIMER_BITS_DEF  = 10;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Stream widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_array_type;

   typedef enum logic [CFG_ADDR_W-1:0] {
      REG_RST_LOW     = 3'd0,
      REG_RST_RELEASE = 3'd1,
      REG_RST_SETTLE  = 3'd2,
      REG_RD_SAMPLE   = 3'd3,
      REG_RD_RECOVERY = 3'd4,
      REG_WR_LEAD     = 3'd5,
      REG_WR_HOLD     = 3'd6
   } reg_idx_type;

   // Reset values, highest index first
   localparam cfg_array_type CFG_RESET = {
      10'd40,   // write hold
      10'd16,   // write lead
      10'd60,   // read recovery
      10'd8,    // read sample
      10'd10,   // reset settle
      10'd60,   // reset release
      10'd450   // reset low
   };

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_RST_LOW    = 4'd1,
      PH_RST_REL    = 4'd2,
      PH_RST_SETTLE = 4'd3,
      PH_RST_POLL   = 4'd4,
      PH_RD_PULSE   = 4'd5,
      PH_RD_WAIT    = 4'd6,
      PH_RD_REC     = 4'd7,
      PH_WR_LEAD    = 4'd8,
      PH_WR_PULSE   = 4'd9,
      PH_WR_HOLD    = 4'd10
   } phase_type;

   // One classified tick as it travels through the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       line_high;
   } item_type;

endpackage

@@ hw/rtl/one_wire_bus_master.sv @@
// A req transaction is first written into the input queue; the sequencer then
// takes it and registers the result that goes out on rsp.
// Throughput: 1 tick per cycle while rsp_tready holds; the sequencer advances its
// phase state once per tick it takes, and the queue (two entries by default) buffers ticks.
// Reset (synchronous, active high): queue empty, sequencer idle, timers and
// bytes cleared, configuration registers back to their default durations.
module one_wire_bus_master
   import owbm_pkg::*;
#(
   parameter int TIMER_BITS  = TIMER_BITS_DEF,   // 8..16, width of the phase timer
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // ticks buffered ahead of the sequencer
) (
   input  logic                   clock,
   input  logic                   reset,
   // tick stream in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd[1:0], data_byte[9:2], line_high[10], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // result stream out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // drive_low[0], busy_res[1], done_res[2], read_byte[10:3], rejected[11], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [CFG_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cfg_array_type cfg_ff;
   logic          item_valid;
   logic          item_pop;
   item_type      item;

   // Duration registers: drop writes to indexes past the last register.
   // A new value takes effect on the very next tick, even mid-sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en && (csr_addr < CFG_ADDR_W'(NUM_REGS))) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   // Front: accept and classify ticks, buffer them ahead of the sequencer
   owbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   // Back: run the bus phases one tick at a time and register each result
   owbm_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hw/rtl/owbm_queue.sv @@
module owbm_queue
   import owbm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd[1:0], data_byte[9:2], line_high[10], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   item_valid,
   input  logic                   item_pop,
   output item_type               item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;
   item_type           item_in;

   // Classify the incoming word into command, data and line level
   always_comb begin
      item_in.cmd       = cmd_type'(req_tdata[1:0]);
      item_in.data_byte = req_tdata[9:2];
      item_in.line_high = req_tdata[10];
   end

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign item_valid = (count_ff != '0);
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;
   assign item       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ hw/rtl/owbm_engine.sv @@
module owbm_engine
   import owbm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_array_type          cfg,
   input  logic                   item_valid,
   output logic                   item_pop,
   input  item_type               item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // drive_low[0], busy_res[1], done_res[2], read_byte[10:3], rejected[11]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int EXT_W = CFG_W + TIMER_BITS;

   phase_type              phase_ff, phase_in;
   logic [TIMER_BITS-1:0]  tick_count_ff, tick_count_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic [7:0]             result_byte_ff, result_byte_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   phase_type              ph0;
   logic [TIMER_BITS-1:0]  tc0;
   logic [2:0]             bi0;
   logic [7:0]             sb0;
   logic [7:0]             sb_sampled;
   logic                   rejected;
   logic                   drive;
   logic                   done;
   logic                   busy;
   reg_idx_type            reg_sel;
   logic [EXT_W-1:0]       dur_ext;
   logic [TIMER_BITS-1:0]  dur;
   logic [TIMER_BITS-1:0]  dur_eff;
   logic                   t_end;
   logic [TIMER_BITS-1:0]  tc_timed;
   logic                   step;

   // Advance one tick whenever an item waits and the output slot is free
   assign step     = item_valid && (!rsp_tvalid_ff || rsp_tready);
   assign item_pop = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         result_byte_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (step) begin
            phase_ff       <= phase_in;
            tick_count_ff  <= tick_count_in;
            bit_index_ff   <= bit_index_in;
            shift_byte_ff  <= shift_byte_in;
            result_byte_ff <= result_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   always_comb begin
      // Start a sequence when idle, otherwise flag a nonzero command
      ph0      = phase_ff;
      tc0      = tick_count_ff;
      bi0      = bit_index_ff;
      sb0      = shift_byte_ff;
      rejected = 1'b0;
      if (phase_ff != PH_IDLE) begin
         rejected = (item.cmd != CMD_TICK);
      end else begin
         unique case (item.cmd)
            CMD_TICK: begin
            end
            CMD_RESET: begin
               ph0 = PH_RST_LOW;
               tc0 = '0;
            end
            CMD_WRITE: begin
               ph0 = PH_WR_LEAD;
               tc0 = '0;
               bi0 = '0;
               sb0 = item.data_byte;
            end
            CMD_READ: begin
               ph0 = PH_RD_PULSE;
               tc0 = '0;
               bi0 = '0;
               sb0 = '0;
            end
         endcase
      end

      // Shared phase timer
      unique case (ph0)
         PH_RST_REL:    reg_sel = REG_RST_RELEASE;
         PH_RST_SETTLE: reg_sel = REG_RST_SETTLE;
         PH_RD_WAIT:    reg_sel = REG_RD_SAMPLE;
         PH_RD_REC:     reg_sel = REG_RD_RECOVERY;
         PH_WR_LEAD:    reg_sel = REG_WR_LEAD;
         PH_WR_HOLD:    reg_sel = REG_WR_HOLD;
         default:       reg_sel = REG_RST_LOW;
      endcase
      dur_ext  = EXT_W'(cfg[reg_sel]);
      dur      = dur_ext[TIMER_BITS-1:0];
      dur_eff  = (dur == '0) ? TIMER_BITS'(1) : dur;
      t_end    = ({1'b0, tc0} + (TIMER_BITS + 1)'(1)) >= {1'b0, dur_eff};
      tc_timed = t_end ? '0 : tc0 + TIMER_BITS'(1);

      // Capture the line on the first recovery tick
      sb_sampled = (tc0 == '0) ? {item.line_high, sb0[7:1]} : sb0;

      phase_in       = ph0;
      tick_count_in  = tc0;
      bit_index_in   = bi0;
      shift_byte_in  = sb0;
      result_byte_in = result_byte_ff;
      drive          = 1'b0;
      done           = 1'b0;

      unique case (ph0)
         PH_IDLE: begin
         end
         PH_RST_LOW: begin
            drive         = 1'b1;
            tick_count_in = tc_timed;
            if (t_end) phase_in = PH_RST_REL;
         end
         PH_RST_REL: begin
            tick_count_in = tc_timed;
            if (t_end) phase_in = PH_RST_SETTLE;
         end
         PH_RST_SETTLE: begin
            tick_count_in = tc_timed;
            if (t_end) phase_in = PH_RST_POLL;
         end
         PH_RST_POLL: begin
            if (item.line_high) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         PH_RD_PULSE: begin
            drive         = 1'b1;
            tick_count_in = '0;
            phase_in      = PH_RD_WAIT;
         end
         PH_RD_WAIT: begin
            tick_count_in = tc_timed;
            if (t_end) phase_in = PH_RD_REC;
         end
         PH_RD_REC: begin
            shift_byte_in = sb_sampled;
            tick_count_in = tc_timed;
            if (t_end) begin
               if (bi0 == 3'd7) begin
                  result_byte_in = sb_sampled;
                  bit_index_in   = '0;
                  phase_in       = PH_IDLE;
                  done           = 1'b1;
               end else begin
                  bit_index_in = bi0 + 3'd1;
                  phase_in     = PH_RD_PULSE;
               end
            end
         end
         PH_WR_LEAD: begin
            tick_count_in = tc_timed;
            if (t_end) phase_in = PH_WR_PULSE;
         end
         PH_WR_PULSE: begin
            drive         = 1'b1;
            tick_count_in = '0;
            phase_in      = PH_WR_HOLD;
         end
         PH_WR_HOLD: begin
            drive         = ~sb0[0];
            tick_count_in = tc_timed;
            if (t_end) begin
               shift_byte_in = {1'b0, sb0[7:1]};
               if (bi0 == 3'd7) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end else begin
                  bit_index_in = bi0 + 3'd1;
                  phase_in     = PH_WR_PULSE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      busy         = (phase_in != PH_IDLE);
      rsp_tdata_in = RSP_TDATA_W'({rejected, result_byte_in, done, busy, drive});

      // Hold the result until taken, refill when a new tick steps
      rsp_tvalid_in = rsp_tvalid_ff;
      if (step) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ hw/rtl/owbm_checker.sv @@
module owbm_checker
   import owbm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // A completing tick never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[1]))
      else $error("done and busy together");

   // With no sequence running or ending, the line stays released
   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] && !rsp_tdata[2] |-> !rsp_tdata[0])
      else $error("line driven while idle");

   // No result appears in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import owbm_pkg::*;

   // Line levels that a test asks for while it clocks a sequence to its end
   localparam logic [1:0] LINE_LOW    = 2'd0;
   localparam logic [1:0] LINE_HIGH   = 2'd1;
   localparam logic [1:0] LINE_RANDOM = 2'd2;

   // Register index past the last register; writes to it must be ignored
   localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

   // Generous bound on the whole run, several times the slowest legal run
   localparam int CYCLE_LIMIT = 500_000;

   // Result fields as they sit in rsp_tdata, highest bits first
   typedef struct packed {
      logic [3:0] fill;
      logic       rejected;
      logic [7:0] read_byte;
      logic       done;
      logic       busy;
      logic       drive_low;
   } tick_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;    // cmd[1:0], data_byte[9:2], line_high[10]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // drive_low[0], busy_res[1], done_res[2],
                                         // read_byte[10:3], rejected[11]
   logic                   csr_wr_en;
   logic [CFG_ADDR_W-1:0]  csr_addr;
   logic [CFG_W-1:0]       csr_wdata;

   // Shadow copy of the bus master: configuration and sequencer state
   logic [CFG_W-1:0] cfg_ticks [NUM_REGS];
   phase_type        bus_phase;
   logic [9:0]       tick_cnt;
   logic [2:0]       bit_idx;
   logic [7:0]       shift_q;
   logic [7:0]       result_q;

   // Results predicted for accepted ticks, oldest first
   tick_result_type  predicted_ticks [$];

   int mismatches = 0;
   int cycle_count = 0;

   // Idling controls shared by the sender, the receiver and the tests
   bit tx_gaps_on;
   int tx_burst_left;
   bit rx_stalls_on;
   int rx_hold_req;

   one_wire_bus_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Bus master prediction
   // ---------------------------------------------------------------------

   // Count one tick of a timed phase; report whether the phase has run out.
   // A register holding zero behaves as a one-tick duration.
   function automatic logic timer_lapsed(reg_idx_type idx);
      int unsigned span;
      span = 32'(cfg_ticks[idx]);
      if (span == 0) span = 1;
      if (tick_cnt + 1 >= span) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 10'd1;
      return 1'b0;
   endfunction

   // Advance the shadow bus master by one tick and return what it shows
   function automatic tick_result_type step_bus_master(cmd_type cmd, logic [7:0] data,
                                                       logic line);
      tick_result_type res;
      logic            drive;
      logic            done;
      res   = '0;
      drive = 1'b0;
      done  = 1'b0;

      // A command while a sequence runs is dropped, even on its last tick
      if (bus_phase != PH_IDLE) begin
         res.rejected = (cmd != CMD_TICK);
      end else begin
         case (cmd)
            CMD_RESET: begin
               bus_phase = PH_RST_LOW;
               tick_cnt  = '0;
            end
            CMD_WRITE: begin
               bus_phase = PH_WR_LEAD;
               tick_cnt  = '0;
               bit_idx   = '0;
               shift_q   = data;
            end
            CMD_READ: begin
               bus_phase = PH_RD_PULSE;
               tick_cnt  = '0;
               bit_idx   = '0;
               shift_q   = '0;
            end
            default: ;
         endcase
      end

      // The tick that starts a sequence is also its first tick
      case (bus_phase)
         PH_RST_LOW: begin
            drive = 1'b1;
            if (timer_lapsed(REG_RST_LOW)) bus_phase = PH_RST_REL;
         end
         PH_RST_REL: begin
            if (timer_lapsed(REG_RST_RELEASE)) bus_phase = PH_RST_SETTLE;
         end
         PH_RST_SETTLE: begin
            if (timer_lapsed(REG_RST_SETTLE)) bus_phase = PH_RST_POLL;
         end
         PH_RST_POLL: begin
            // No timeout: a line held low keeps the sequence busy
            if (line) begin
               bus_phase = PH_IDLE;
               done      = 1'b1;
            end
         end
         PH_RD_PULSE: begin
            drive     = 1'b1;
            tick_cnt  = '0;
            bus_phase = PH_RD_WAIT;
         end
         PH_RD_WAIT: begin
            if (timer_lapsed(REG_RD_SAMPLE)) bus_phase = PH_RD_REC;
         end
         PH_RD_REC: begin
            // Sample on the first recovery tick, shifting in from the top
            if (tick_cnt == 0) shift_q = {line, shift_q[7:1]};
            if (timer_lapsed(REG_RD_RECOVERY)) begin
               if (bit_idx == 3'd7) begin
                  result_q  = shift_q;
                  bit_idx   = '0;
                  bus_phase = PH_IDLE;
                  done      = 1'b1;
               end else begin
                  bit_idx   = bit_idx + 3'd1;
                  bus_phase = PH_RD_PULSE;
               end
            end
         end
         PH_WR_LEAD: begin
            if (timer_lapsed(REG_WR_LEAD)) bus_phase = PH_WR_PULSE;
         end
         PH_WR_PULSE: begin
            drive     = 1'b1;
            tick_cnt  = '0;
            bus_phase = PH_WR_HOLD;
         end
         PH_WR_HOLD: begin
            drive = ~shift_q[0];
            if (timer_lapsed(REG_WR_HOLD)) begin
               shift_q = shift_q >> 1;
               if (bit_idx == 3'd7) begin
                  bit_idx   = '0;
                  bus_phase = PH_IDLE;
                  done      = 1'b1;
               end else begin
                  bit_idx   = bit_idx + 3'd1;
                  bus_phase = PH_WR_PULSE;
               end
            end
         end
         default: ;   // idle: release the line, keep everything
      endcase

      res.drive_low = drive;
      res.busy      = (bus_phase != PH_IDLE);
      res.done      = done;
      res.read_byte = result_q;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
   endtask

   // Compare every result transaction with the oldest prediction
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (predicted_ticks.size() == 0) begin
            note_mismatch("unexpected result", 0, 32'(got));
         end else begin
            want = predicted_ticks.pop_front();
            if (got.drive_low != want.drive_low)
               note_mismatch("drive_low", 32'(want.drive_low), 32'(got.drive_low));
            if (got.busy != want.busy)
               note_mismatch("busy", 32'(want.busy), 32'(got.busy));
            if (got.done != want.done)
               note_mismatch("done", 32'(want.done), 32'(got.done));
            if (got.read_byte != want.read_byte)
               note_mismatch("read_byte", 32'(want.read_byte), 32'(got.read_byte));
            if (got.rejected != want.rejected)
               note_mismatch("rejected", 32'(want.rejected), 32'(got.rejected));
            if (got.fill != want.fill)
               note_mismatch("zero fill", 32'(want.fill), 32'(got.fill));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: alternate ready and stalled runs of random length, or hold
   // off for a requested number of cycles
   // ---------------------------------------------------------------------

   initial begin
      int rx_hold_left;
      int rx_run_left;
      bit rx_level;
      rx_hold_left = 0;
      rx_run_left  = 0;
      rx_level     = 1'b0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else if (!rx_stalls_on) begin
            rsp_tready <= 1'b1;
         end else begin
            if (rx_run_left == 0) begin
               rx_level    = !rx_level;
               rx_run_left = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run_left--;
            rsp_tready <= rx_level;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one tick, wait for its transaction and record the prediction.
   // Enter and leave just after a falling edge.
   task automatic send_tick(cmd_type cmd, logic [7:0] data, logic line);
      if (tx_gaps_on) begin
         // Close the burst with a gap, then open a new one
         if (tx_burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            tx_burst_left = $urandom_range(1, 24);
         end
         tx_burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, line, data, cmd};
      do @(posedge clock); while (!req_tready);
      predicted_ticks.push_back(step_bus_master(cmd, data, line));
      @(negedge clock);
   endtask

   // Clock plain ticks until the running sequence has ended
   task automatic run_to_idle(logic [1:0] line_mode);
      logic line;
      while (bus_phase != PH_IDLE) begin
         // Let the reset poll see a high line sooner or later
         if (bus_phase == PH_RST_POLL || line_mode == LINE_RANDOM)
            line = 1'($urandom_range(0, 1));
         else
            line = (line_mode == LINE_HIGH);
         send_tick(CMD_TICK, 8'($urandom), line);
      end
   endtask

   // Mostly well-formed traffic: start sequences when idle, tick them along,
   // now and then throw a command at a busy master
   task automatic send_random_tick();
      cmd_type     cmd;
      logic        line;
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (bus_phase == PH_IDLE)
         cmd = (pick < 3) ? CMD_TICK : (pick < 7) ? CMD_RESET :
               (pick < 11) ? CMD_WRITE : CMD_READ;
      else
         cmd = (pick == 0) ? cmd_type'($urandom_range(1, 3)) : CMD_TICK;
      // Keep the line low for a while during the reset poll
      line = (bus_phase == PH_RST_POLL) ? ($urandom_range(0, 4) == 0)
                                        : 1'($urandom_range(0, 1));
      send_tick(cmd, 8'($urandom), line);
   endtask

   // Stop offering, let every predicted result come back, then let the
   // pipeline settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (predicted_ticks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all seven registers, then poke the unused index with noise
   task automatic apply_config(input logic [CFG_W-1:0] vals [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_wr_en    <= 1'b1;
         csr_addr     <= reg_idx_type'(i);
         csr_wdata    <= vals[i];
         cfg_ticks[i]  = vals[i];
         @(negedge clock);
      end
      csr_addr  <= REG_UNUSED;
      csr_wdata <= CFG_W'($urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] random_ticks();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return CFG_W'($urandom_range(7, 40));
      return CFG_W'($urandom_range(1, 6));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Run a full bus reset on the durations left by reset, then the first
   // bit of a write and of a read before cutting their bit times short
   task automatic test_reset_defaults();
      logic [CFG_W-1:0] vals [NUM_REGS];
      vals = cfg_ticks;
      send_tick(CMD_RESET, 8'($urandom), 1'b0);
      run_to_idle(LINE_RANDOM);

      // Lead and first bit hold, into the second bit
      send_tick(CMD_WRITE, 8'hA5, 1'b1);
      repeat (64) send_tick(CMD_TICK, 8'($urandom), 1'b1);
      wait_drained();
      vals[REG_WR_HOLD] = CFG_W'(2);
      apply_config(vals);
      run_to_idle(LINE_RANDOM);

      // First sample wait and recovery, into the second bit
      send_tick(CMD_READ, 8'($urandom), 1'b0);
      repeat (76) send_tick(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
      wait_drained();
      vals[REG_RD_RECOVERY] = CFG_W'(2);
      apply_config(vals);
      run_to_idle(LINE_RANDOM);
   endtask

   // Zero durations, idle ticks, stuck line, rejects and data extremes
   task automatic test_min_durations();
      logic [CFG_W-1:0] vals [NUM_REGS];
      foreach (vals[i]) vals[i] = '0;
      wait_drained();
      apply_config(vals);

      // Idle ticks leave everything alone
      send_tick(CMD_TICK, 8'h00, 1'b0);
      send_tick(CMD_TICK, 8'hFF, 1'b1);

      // Bus reset with a write thrown at it and a line stuck low in the poll
      send_tick(CMD_RESET, 8'h00, 1'b1);
      send_tick(CMD_WRITE, 8'hFF, 1'b1);
      send_tick(CMD_TICK, 8'h00, 1'b0);
      repeat (30) send_tick(CMD_TICK, 8'h00, 1'b0);
      // Release the line; the read lands on the completing tick and is dropped
      send_tick(CMD_READ, 8'h3C, 1'b1);

      send_tick(CMD_WRITE, 8'h00, 1'b0);
      run_to_idle(LINE_RANDOM);
      send_tick(CMD_WRITE, 8'hFF, 1'b1);
      send_tick(CMD_RESET, 8'h00, 1'b0);
      run_to_idle(LINE_RANDOM);
      send_tick(CMD_READ, 8'h00, 1'b1);
      run_to_idle(LINE_HIGH);
      send_tick(CMD_READ, 8'hFF, 1'b0);
      run_to_idle(LINE_LOW);
   endtask

   // Shorten a duration while its phase is running
   task automatic test_config_while_busy();
      logic [CFG_W-1:0] vals [NUM_REGS];
      foreach (vals[i]) vals[i] = CFG_W'(2);
      vals[REG_RST_LOW] = CFG_W'(300);
      vals[REG_WR_HOLD] = CFG_W'(100);
      wait_drained();
      apply_config(vals);

      // Cut the reset low below the ticks already spent in it
      send_tick(CMD_RESET, 8'($urandom), 1'b0);
      repeat (12) send_tick(CMD_TICK, 8'($urandom), 1'b0);
      wait_drained();
      vals[REG_RST_LOW] = CFG_W'(5);
      apply_config(vals);
      run_to_idle(LINE_RANDOM);

      // Same for a write hold in the middle of a bit
      send_tick(CMD_WRITE, 8'h96, 1'b1);
      repeat (30) send_tick(CMD_TICK, 8'($urandom), 1'b1);
      wait_drained();
      vals[REG_WR_HOLD] = CFG_W'(1);
      apply_config(vals);
      run_to_idle(LINE_RANDOM);
   endtask

   // Largest durations everywhere: start each sequence on them, count well
   // into the long phase, then cut every duration to one tick
   task automatic test_long_durations();
      logic [CFG_W-1:0] vals [NUM_REGS];
      logic [CFG_W-1:0] short_vals [NUM_REGS];
      foreach (vals[i]) vals[i] = {CFG_W{1'b1}};
      foreach (short_vals[i]) short_vals[i] = CFG_W'(1);
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;

      wait_drained();
      apply_config(vals);
      send_tick(CMD_RESET, 8'($urandom), 1'b0);
      repeat (20) send_tick(CMD_TICK, 8'($urandom), 1'b0);
      wait_drained();
      apply_config(short_vals);
      run_to_idle(LINE_RANDOM);

      wait_drained();
      apply_config(vals);
      send_tick(CMD_WRITE, 8'h5A, 1'b0);
      repeat (20) send_tick(CMD_TICK, 8'($urandom), 1'b0);
      wait_drained();
      apply_config(short_vals);
      run_to_idle(LINE_RANDOM);

      wait_drained();
      apply_config(vals);
      send_tick(CMD_READ, 8'($urandom), 1'b1);
      repeat (20) send_tick(CMD_TICK, 8'($urandom), 1'b1);
      wait_drained();
      apply_config(short_vals);
      run_to_idle(LINE_RANDOM);

      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // Hold the receiver off while ticks keep coming, so the input stalls
   task automatic test_backpressure();
      logic [CFG_W-1:0] vals [NUM_REGS];
      foreach (vals[i]) vals[i] = random_ticks();
      wait_drained();
      apply_config(vals);
      tx_gaps_on  = 1'b0;
      rx_hold_req = 80;
      repeat (60) send_random_tick();
      tx_gaps_on  = 1'b1;
      // Pause the sender until every result is back
      wait_drained();
   endtask

   // Random traffic over several random settings and idling mixes
   task automatic test_random_traffic();
      logic [CFG_W-1:0] vals [NUM_REGS];
      for (int p = 0; p < 4; p++) begin
         foreach (vals[i]) vals[i] = random_ticks();
         wait_drained();
         apply_config(vals);
         tx_gaps_on   = (p % 4) != 2 && (p % 4) != 3;
         rx_stalls_on = (p % 4) != 1 && (p % 4) != 3;
         repeat (45) send_random_tick();
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;

      tx_gaps_on    = 1'b1;
      tx_burst_left = 0;
      rx_stalls_on  = 1'b1;
      rx_hold_req   = 0;

      // Shadow state after reset: default durations, sequencer idle
      cfg_ticks = '{10'd450, 10'd60, 10'd10, 10'd8, 10'd60, 10'd16, 10'd40};
      bus_phase = PH_IDLE;
      tick_cnt  = '0;
      bit_idx   = '0;
      shift_q   = '0;
      result_q  = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_min_durations();
      test_config_while_busy();
      test_long_durations();
      test_backpressure();
      test_random_traffic();

      // Drain, then give stray results a chance to show up
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
